FILE: hw/rtl/msc_pkg.sv
// Shared types and constants for the MIPS subset core.
// No dependencies; imported by msc_front, msc_queue, msc_back and the top level.
package msc_pkg;

    localparam logic [5:0]  OP_RTYPE  = 6'b000000;
    localparam logic [5:0]  OP_LW     = 6'b100011;
    localparam logic [5:0]  OP_SW     = 6'b101011;
    localparam logic [31:0] HALT_WORD = 32'hFFFF_FFFF;

    localparam logic [2:0] FN_ADDU = 3'd1;
    localparam logic [2:0] FN_SUBU = 3'd3;
    localparam logic [2:0] FN_AND  = 3'd4;
    localparam logic [2:0] FN_OR   = 3'd5;
    localparam logic [2:0] FN_NOR  = 3'd7;

    localparam logic REQ_PRELOAD = 1'b1;

    typedef enum logic [2:0] {
        KIND_RTYPE   = 3'd0,
        KIND_LOAD    = 3'd1,
        KIND_STORE   = 3'd2,
        KIND_IGNORED = 3'd3,
        KIND_HALT    = 3'd4,
        KIND_PRELOAD = 3'd5
    } kind_t;

    // One classified request as it travels from front to back.
    typedef struct packed {
        kind_t       kind;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [4:0]  rd;
        logic [2:0]  funct;
        logic [15:0] imm;
        logic [15:0] pre_addr;
        logic [7:0]  pre_byte;
        logic        halted;
    } entry_t;

endpackage

FILE: hw/rtl/msc_front.sv
// Front end: accepts requests, classifies them and tracks the halt state.
// Depends on msc_pkg; feeds msc_queue.
module msc_front import msc_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [31:0] instruction,
    input  logic [15:0] preload_address,
    input  logic [7:0]  preload_byte,
    input  logic        q_full,
    output logic        push,
    output entry_t      push_entry
);

    logic halt_seen_reg;
    logic halt_seen_next;

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        push_entry.kind     = KIND_IGNORED;
        push_entry.rs       = instruction[25:21];
        push_entry.rt       = instruction[20:16];
        push_entry.rd       = instruction[15:11];
        push_entry.funct    = instruction[2:0];
        push_entry.imm      = instruction[15:0];
        push_entry.pre_addr = preload_address;
        push_entry.pre_byte = preload_byte;
        push_entry.halted   = halt_seen_reg;
        if (req_type == REQ_PRELOAD)
        begin
            push_entry.kind = KIND_PRELOAD;
        end
        else if (halt_seen_reg)
        begin
            push_entry.kind = KIND_IGNORED;
        end
        else if (instruction == HALT_WORD)
        begin
            push_entry.kind   = KIND_HALT;
            push_entry.halted = 1'b1;
        end
        else
        begin
            case (instruction[31:26])
                OP_RTYPE: push_entry.kind = KIND_RTYPE;
                OP_LW:    push_entry.kind = KIND_LOAD;
                OP_SW:    push_entry.kind = KIND_STORE;
                default:  push_entry.kind = KIND_IGNORED;
            endcase
        end
    end

    assign halt_seen_next = halt_seen_reg || (push && push_entry.kind == KIND_HALT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            halt_seen_reg <= 1'b0;
        end
        else
        begin
            halt_seen_reg <= halt_seen_next;
        end
    end

endmodule

FILE: hw/rtl/msc_queue.sv
// Two-entry request queue between front and back end.
// Depends on msc_pkg for the entry type.
module msc_queue import msc_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    input  logic   pop,
    output entry_t head,
    output logic   empty
);

    entry_t     slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full       = count_reg == 2'd2;
    assign empty      = count_reg == 2'd0;
    assign head       = slot_reg[rd_ptr_reg];
    assign count_next = count_reg + 2'(push) - 2'(pop);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

FILE: hw/rtl/msc_addr_mod.sv
// Three-stage address reduction: r = x mod DATA_BYTES by reciprocal multiply.
// No package dependency; used by msc_back.
module msc_addr_mod #(
    parameter int DATA_BYTES = 65536
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [31:0]                   x,
    output logic                          done,
    output logic [$clog2(DATA_BYTES)-1:0] r
);

    localparam int     ADDR_W  = $clog2(DATA_BYTES);
    localparam int     QW      = 33 - ADDR_W;
    localparam int     RW      = ADDR_W + 2;
    localparam longint RECIP   = (64'd1 << 32) / DATA_BYTES;
    localparam logic [QW-1:0] RECIP_C = QW'(RECIP);
    localparam logic [RW-1:0] SIZE_C  = RW'(DATA_BYTES);

    logic [2:0]       vld_reg;
    logic [32+QW-1:0] prod_reg;
    logic [31:0]      x1_reg;
    logic [RW-1:0]    x2_reg;
    logic [RW-1:0]    qn_reg;
    logic [QW-1:0]    quot;
    logic [RW-1:0]    r_raw;
    logic [ADDR_W-1:0] r_reg;

    // Quotient estimate is low by at most one, so the remainder stays below 2*N.
    assign quot  = prod_reg[32+QW-1:32];
    assign r_raw = x2_reg - qn_reg;
    assign done  = vld_reg[2];
    assign r     = r_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= (32+QW)'(x) * (32+QW)'(RECIP_C);
        x1_reg   <= x;
        qn_reg   <= RW'(quot) * SIZE_C;
        x2_reg   <= x1_reg[RW-1:0];
        r_reg    <= (r_raw >= SIZE_C) ? ADDR_W'(r_raw - SIZE_C) : ADDR_W'(r_raw);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 3'b000;
        end
        else
        begin
            vld_reg <= {vld_reg[1:0], start};
        end
    end

endmodule

FILE: hw/rtl/msc_back.sv
// Back end: register file, ALU, banked data memory and result register.
// Depends on msc_pkg and msc_addr_mod.
module msc_back import msc_pkg::*; #(
    parameter int DATA_BYTES = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_empty,
    input  entry_t      q_head,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  kind,
    output logic        reg_written,
    output logic [4:0]  dest_reg,
    output logic [31:0] reg_value,
    output logic        mem_written,
    output logic [15:0] mem_address,
    output logic [31:0] mem_value,
    output logic        halted
);

    localparam int ADDR_W     = $clog2(DATA_BYTES);
    localparam int ROWS       = (DATA_BYTES + 3) / 4;
    localparam bit NEED_SPLIT = (DATA_BYTES % 4) != 0;
    localparam logic [ADDR_W:0] SIZE_C = (ADDR_W+1)'(DATA_BYTES);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_EXEC = 6'b000010,
        ST_MOD  = 6'b000100,
        ST_MEM  = 6'b001000,
        ST_MEMQ = 6'b010000,
        ST_WB   = 6'b100000
    } state_t;

    state_t      state_reg;
    state_t      state_next;
    entry_t      cur_reg;

    logic [31:0] rf_mem [32];
    logic [31:0] rf_vld_reg;
    logic [31:0] ra_reg;
    logic [31:0] rb_reg;
    logic        ra_vld_reg;
    logic        rb_vld_reg;
    logic        rf_we;
    logic [4:0]  rf_waddr;
    logic [31:0] rf_wdata;

    logic [31:0] last_alu_reg;
    logic [31:0] op_a;
    logic [31:0] op_b;
    logic [31:0] alu_val;

    logic              mod_start;
    logic [31:0]       mod_x;
    logic              mod_done;
    logic [ADDR_W-1:0] mod_r;

    logic [ADDR_W-1:0] ea_reg;
    logic              pass_reg;
    logic [31:0]       ld_word_reg;

    logic [ADDR_W:0]   sum_k  [4];
    logic [ADDR_W-1:0] p_addr [4];
    logic [7:0]        st_byte [4];
    logic [3:0]        wrap;
    logic [3:0]        act;
    logic              split;
    logic [3:0]        bank_en;
    logic [3:0]        bank_we;
    logic [3:0]        bank_re;
    logic [ADDR_W-3:0] bank_row [4];
    logic [7:0]        bank_wdata [4];
    logic [7:0]        bank_q [4];

    logic        out_free;
    logic        load_out;
    logic [2:0]  res_kind;
    logic        res_rw;
    logic [4:0]  res_dst;
    logic [31:0] res_rv;
    logic        res_mw;
    logic [15:0] res_ma;
    logic [31:0] res_mv;

    logic        out_valid_reg;
    logic [2:0]  out_kind_reg;
    logic        out_rw_reg;
    logic [4:0]  out_dst_reg;
    logic [31:0] out_rv_reg;
    logic        out_mw_reg;
    logic [15:0] out_ma_reg;
    logic [31:0] out_mv_reg;
    logic        out_halted_reg;

    assign op_a     = ra_vld_reg ? ra_reg : 32'd0;
    assign op_b     = rb_vld_reg ? rb_reg : 32'd0;
    assign out_free = !out_valid_reg || !out_stall;
    assign mod_x    = (cur_reg.kind == KIND_PRELOAD) ? {16'd0, cur_reg.pre_addr}
                                                     : op_a + {{16{cur_reg.imm[15]}}, cur_reg.imm};

    msc_addr_mod #(
        .DATA_BYTES(DATA_BYTES)
    ) u_addr_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mod_start),
        .x     (mod_x),
        .done  (mod_done),
        .r     (mod_r)
    );

    // Unknown funct codes pass the previous ALU result through.
    always_comb
    begin
        case (cur_reg.funct)
            FN_ADDU: alu_val = op_a + op_b;
            FN_SUBU: alu_val = op_a - op_b;
            FN_AND:  alu_val = op_a & op_b;
            FN_OR:   alu_val = op_a | op_b;
            FN_NOR:  alu_val = ~(op_a | op_b);
            default: alu_val = last_alu_reg;
        endcase
    end

    // Byte lanes of the word at ea. When the size is not a multiple of four a
    // word crossing the end can hit one bank twice: wrapped bytes go in a second pass.
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            sum_k[k]   = {1'b0, ea_reg} + (ADDR_W+1)'(k);
            wrap[k]    = sum_k[k] >= SIZE_C;
            p_addr[k]  = wrap[k] ? ADDR_W'(sum_k[k] - SIZE_C) : ADDR_W'(sum_k[k]);
            st_byte[k] = (cur_reg.kind == KIND_PRELOAD) ? cur_reg.pre_byte
                                                        : op_b[31-8*k -: 8];
        end
        split = NEED_SPLIT && (cur_reg.kind != KIND_PRELOAD) && (|wrap);
        for (int k = 0; k < 4; k++)
        begin
            if (cur_reg.kind == KIND_PRELOAD)
            begin
                act[k] = (k == 0);
            end
            else if (split)
            begin
                act[k] = pass_reg ? wrap[k] : !wrap[k];
            end
            else
            begin
                act[k] = 1'b1;
            end
        end
        for (int b = 0; b < 4; b++)
        begin
            bank_en[b]    = 1'b0;
            bank_row[b]   = '0;
            bank_wdata[b] = 8'd0;
            for (int k = 0; k < 4; k++)
            begin
                if (act[k] && p_addr[k][1:0] == 2'(b))
                begin
                    bank_en[b]    = 1'b1;
                    bank_row[b]   = p_addr[k][ADDR_W-1:2];
                    bank_wdata[b] = st_byte[k];
                end
            end
        end
        bank_we = (state_reg == ST_MEM && cur_reg.kind != KIND_LOAD) ? bank_en : 4'b0000;
        bank_re = (state_reg == ST_MEM && cur_reg.kind == KIND_LOAD) ? bank_en : 4'b0000;
    end

    for (genvar g = 0; g < 4; g++)
    begin : g_bank
        logic [7:0] mem [ROWS];

        always_ff @(posedge clk)
        begin
            if (bank_we[g])
            begin
                mem[bank_row[g]] <= bank_wdata[g];
            end
            if (bank_re[g])
            begin
                bank_q[g] <= mem[bank_row[g]];
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        mod_start  = 1'b0;
        load_out   = 1'b0;
        rf_we      = 1'b0;
        rf_waddr   = cur_reg.rd;
        rf_wdata   = alu_val;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                case (cur_reg.kind)
                    KIND_LOAD, KIND_STORE, KIND_PRELOAD:
                    begin
                        mod_start  = 1'b1;
                        state_next = ST_MOD;
                    end
                    default:
                    begin
                        if (out_free)
                        begin
                            load_out   = 1'b1;
                            state_next = ST_IDLE;
                            rf_we      = (cur_reg.kind == KIND_RTYPE) && (cur_reg.rd != 5'd0);
                        end
                    end
                endcase
            end
            ST_MOD:
            begin
                if (mod_done)
                begin
                    state_next = ST_MEM;
                end
            end
            ST_MEM:
            begin
                if (cur_reg.kind == KIND_LOAD)
                begin
                    state_next = ST_MEMQ;
                end
                else if (!(split && !pass_reg))
                begin
                    state_next = ST_WB;
                end
            end
            ST_MEMQ:
            begin
                state_next = (split && !pass_reg) ? ST_MEM : ST_WB;
            end
            ST_WB:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                    rf_we      = (cur_reg.kind == KIND_LOAD) && (cur_reg.rt != 5'd0);
                    rf_waddr   = cur_reg.rt;
                    rf_wdata   = ld_word_reg;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res_kind = cur_reg.kind;
        res_rw   = 1'b0;
        res_dst  = 5'd0;
        res_rv   = 32'd0;
        res_mw   = 1'b0;
        res_ma   = 16'd0;
        res_mv   = 32'd0;
        case (cur_reg.kind)
            KIND_RTYPE:
            begin
                res_dst = cur_reg.rd;
                res_rw  = cur_reg.rd != 5'd0;
                res_rv  = res_rw ? alu_val : 32'd0;
            end
            KIND_LOAD:
            begin
                res_dst = cur_reg.rt;
                res_rw  = cur_reg.rt != 5'd0;
                res_rv  = res_rw ? ld_word_reg : 32'd0;
                res_ma  = 16'(ea_reg);
                res_mv  = ld_word_reg;
            end
            KIND_STORE:
            begin
                res_mw = 1'b1;
                res_ma = 16'(ea_reg);
                res_mv = op_b;
            end
            KIND_PRELOAD:
            begin
                res_mw = 1'b1;
                res_ma = 16'(ea_reg);
                res_mv = {24'd0, cur_reg.pre_byte};
            end
            default:
            begin
            end
        endcase
    end

    // Register file: one write port, two registered read ports.
    always_ff @(posedge clk)
    begin
        if (rf_we)
        begin
            rf_mem[rf_waddr] <= rf_wdata;
        end
        if (q_pop)
        begin
            ra_reg  <= rf_mem[q_head.rs];
            rb_reg  <= rf_mem[q_head.rt];
            cur_reg <= q_head;
        end
        if (state_reg == ST_MOD && mod_done)
        begin
            ea_reg <= mod_r;
        end
        if (state_reg == ST_MEMQ)
        begin
            for (int k = 0; k < 4; k++)
            begin
                if (act[k])
                begin
                    ld_word_reg[31-8*k -: 8] <= bank_q[p_addr[k][1:0]];
                end
            end
        end
        if (load_out)
        begin
            out_kind_reg   <= res_kind;
            out_rw_reg     <= res_rw;
            out_dst_reg    <= res_dst;
            out_rv_reg     <= res_rv;
            out_mw_reg     <= res_mw;
            out_ma_reg     <= res_ma;
            out_mv_reg     <= res_mv;
            out_halted_reg <= cur_reg.halted;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rf_vld_reg    <= 32'd0;
            ra_vld_reg    <= 1'b0;
            rb_vld_reg    <= 1'b0;
            last_alu_reg  <= 32'd0;
            pass_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (rf_we)
            begin
                rf_vld_reg[rf_waddr] <= 1'b1;
            end
            if (q_pop)
            begin
                ra_vld_reg <= rf_vld_reg[q_head.rs];
                rb_vld_reg <= rf_vld_reg[q_head.rt];
            end
            if (load_out && state_reg == ST_EXEC && cur_reg.kind == KIND_RTYPE)
            begin
                last_alu_reg <= alu_val;
            end
            if (state_reg == ST_MOD && mod_done)
            begin
                pass_reg <= 1'b0;
            end
            else if (split && !pass_reg &&
                     ((state_reg == ST_MEM && cur_reg.kind == KIND_STORE) ||
                      state_reg == ST_MEMQ))
            begin
                pass_reg <= 1'b1;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = out_kind_reg;
    assign reg_written = out_rw_reg;
    assign dest_reg    = out_dst_reg;
    assign reg_value   = out_rv_reg;
    assign mem_written = out_mw_reg;
    assign mem_address = out_ma_reg;
    assign mem_value   = out_mv_reg;
    assign halted      = out_halted_reg;

endmodule

FILE: hw/rtl/mips_subset_core.sv
// Top level of the MIPS subset core: front end, request queue, back end.
// Depends on msc_pkg, msc_front, msc_queue, msc_back.
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------------
//  in      | in_valid / in_stall  | req_type, instruction, preload_address, preload_byte
//  out     | out_valid / out_stall| kind, reg_written, dest_reg, reg_value,
//          |                      | mem_written, mem_address, mem_value, halted
//
// Back end steps per request: R-type, halt and ignored words take a register
// read, then execute; a preload or a store adds the address reduction and a
// memory bank write, a load the reduction and a registered bank read. A word
// that wraps past the end of a memory whose size is not a multiple of four
// takes one more memory pass.
// Reset clears the register file valid bits, halt state, queue and result
// register; data memory is not cleared. The 2-entry queue keeps accepting
// requests while a result waits under out_stall, until it is full.
module mips_subset_core import msc_pkg::*; #(
    parameter int DATA_BYTES = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [31:0] instruction,
    input  logic [15:0] preload_address,
    input  logic [7:0]  preload_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  kind,
    output logic        reg_written,
    output logic [4:0]  dest_reg,
    output logic [31:0] reg_value,
    output logic        mem_written,
    output logic [15:0] mem_address,
    output logic [31:0] mem_value,
    output logic        halted
);

    logic   push;
    entry_t push_entry;
    logic   q_full;
    logic   q_pop;
    entry_t q_head;
    logic   q_empty;

    msc_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .req_type        (req_type),
        .instruction     (instruction),
        .preload_address (preload_address),
        .preload_byte    (preload_byte),
        .q_full          (q_full),
        .push            (push),
        .push_entry      (push_entry)
    );

    msc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head       (q_head),
        .empty      (q_empty)
    );

    msc_back #(
        .DATA_BYTES(DATA_BYTES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .reg_written (reg_written),
        .dest_reg    (dest_reg),
        .reg_value   (reg_value),
        .mem_written (mem_written),
        .mem_address (mem_address),
        .mem_value   (mem_value),
        .halted      (halted)
    );

endmodule

FILE: verif/mips_subset_core_tb.sv
// Self-checking testbench for mips_subset_core: directed and random requests with
// per-request result checking against an in-bench execution model.
// Depends on msc_pkg and the mips_subset_core RTL.
`timescale 1ns / 1ps

module mips_subset_core_tb;
    import msc_pkg::*;

    localparam int CHECK = 0;          // state copy advanced on accepted requests
    localparam int PLAN  = 1;          // state copy advanced as requests are generated
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_REQS = 780;

    localparam logic [5:0] OP_ADDI    = 6'h08;   // outside the supported subset
    localparam logic [2:0] FN_UNUSED0 = 3'd0;
    localparam logic [2:0] FN_UNUSED2 = 3'd2;
    localparam logic [2:0] FN_UNUSED6 = 3'd6;

    typedef struct packed {
        logic        req_type;
        logic [31:0] instruction;
        logic [15:0] paddr;
        logic [7:0]  pbyte;
    } cpu_req_t;

    typedef struct packed {
        kind_t       kind;
        logic        reg_written;
        logic [4:0]  dest_reg;
        logic [31:0] reg_value;
        logic        mem_written;
        logic [15:0] mem_address;
        logic [31:0] mem_value;
        logic        halted;
    } cpu_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        req_type = 1'b0;
    logic [31:0] instruction = '0;
    logic [15:0] preload_address = '0;
    logic [7:0]  preload_byte = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  kind;
    logic        reg_written;
    logic [4:0]  dest_reg;
    logic [31:0] reg_value;
    logic        mem_written;
    logic [15:0] mem_address;
    logic [31:0] mem_value;
    logic        halted;

    // two copies of the architectural state
    logic [31:0] gpr [2][32];
    logic [7:0]  dmem [2][65536];
    bit          dmem_set [2][65536];
    logic [31:0] alu_last [2];
    bit          halt_flag [2];

    cpu_req_t    req_pending [$];
    cpu_result_t retire_q [$];
    logic [15:0] stored_words [$];
    cpu_req_t    cur_req;
    cpu_result_t exp_res;
    int          sent_cnt = 0;
    int          errors = 0;
    int          cycle_cnt = 0;
    int          kind_seen [8];
    logic        calm;

    mips_subset_core #(.DATA_BYTES(65536)) dut (.*);

    always #5 clk = ~clk;

    always @(posedge clk) cycle_cnt++;

    // both sides run without idling for a stretch of the run
    assign calm = (sent_cnt >= 300) && (sent_cnt < 450);

    function automatic cpu_result_t retire_request(input int s, input cpu_req_t r);
        cpu_result_t res;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [4:0]  rd;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] w;
        logic [15:0] ea;
        logic [15:0] byte_addr;
        res = '0;
        res.kind = KIND_IGNORED;
        if (r.req_type == REQ_PRELOAD) begin
            dmem[s][r.paddr] = r.pbyte;
            dmem_set[s][r.paddr] = 1'b1;
            res.kind = KIND_PRELOAD;
            res.mem_written = 1'b1;
            res.mem_address = r.paddr;
            res.mem_value = {24'b0, r.pbyte};
        end
        else if (!halt_flag[s]) begin
            if (r.instruction == HALT_WORD) begin
                halt_flag[s] = 1'b1;
                res.kind = KIND_HALT;
            end
            else begin
                rs = r.instruction[25:21];
                rt = r.instruction[20:16];
                rd = r.instruction[15:11];
                a = gpr[s][rs];
                b = gpr[s][rt];
                // sign extension drops out once the sum is taken modulo 64 KiB
                ea = a[15:0] + r.instruction[15:0];
                w = '0;
                case (r.instruction[31:26])
                    OP_RTYPE: begin
                        case (r.instruction[2:0])
                            FN_ADDU: alu_last[s] = a + b;
                            FN_SUBU: alu_last[s] = a - b;
                            FN_AND:  alu_last[s] = a & b;
                            FN_OR:   alu_last[s] = a | b;
                            FN_NOR:  alu_last[s] = ~(a | b);
                            default: ;
                        endcase
                        res.kind = KIND_RTYPE;
                        res.dest_reg = rd;
                        if (rd != 5'd0) begin
                            gpr[s][rd] = alu_last[s];
                            res.reg_written = 1'b1;
                            res.reg_value = alu_last[s];
                        end
                    end
                    OP_LW: begin
                        for (int k = 0; k < 4; k++) begin
                            byte_addr = ea + 16'(k);
                            w = {w[23:0], dmem[s][byte_addr]};
                        end
                        res.kind = KIND_LOAD;
                        res.dest_reg = rt;
                        res.mem_address = ea;
                        res.mem_value = w;
                        if (rt != 5'd0) begin
                            gpr[s][rt] = w;
                            res.reg_written = 1'b1;
                            res.reg_value = w;
                        end
                    end
                    OP_SW: begin
                        for (int k = 0; k < 4; k++) begin
                            byte_addr = ea + 16'(k);
                            dmem[s][byte_addr] = 8'(b >> (24 - 8 * k));
                            dmem_set[s][byte_addr] = 1'b1;
                        end
                        res.kind = KIND_STORE;
                        res.mem_written = 1'b1;
                        res.mem_address = ea;
                        res.mem_value = b;
                    end
                    default: ;
                endcase
            end
        end
        res.halted = halt_flag[s];
        return res;
    endfunction

    function automatic bit word_ready(input int s, input logic [15:0] ea);
        logic [15:0] byte_addr;
        word_ready = 1'b1;
        for (int k = 0; k < 4; k++) begin
            byte_addr = ea + 16'(k);
            if (!dmem_set[s][byte_addr])
                word_ready = 1'b0;
        end
    endfunction

    function automatic cpu_req_t mk_exec(input logic [31:0] ins);
        cpu_req_t r;
        r.req_type = 1'b0;
        r.instruction = ins;
        r.paddr = 16'($urandom());
        r.pbyte = 8'($urandom());
        return r;
    endfunction

    function automatic cpu_req_t mk_preload(input logic [15:0] addr, input logic [7:0] data);
        cpu_req_t r;
        r.req_type = REQ_PRELOAD;
        r.instruction = $urandom();
        r.paddr = addr;
        r.pbyte = data;
        return r;
    endfunction

    // shamt and funct[5:3] are don't-care bits, so they get random values
    function automatic logic [31:0] rtype(input logic [4:0] rs, input logic [4:0] rt,
                                          input logic [4:0] rd, input logic [2:0] fn);
        return {OP_RTYPE, rs, rt, rd, 5'($urandom()), 3'($urandom()), fn};
    endfunction

    function automatic logic [31:0] mem_ins(input logic [5:0] op, input logic [4:0] rs,
                                            input logic [4:0] rt, input logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    task automatic plan_push(input cpu_req_t r);
        cpu_result_t res;
        res = retire_request(PLAN, r);
        if (res.kind == KIND_STORE)
            stored_words.push_back(res.mem_address);
        req_pending.push_back(r);
    endtask

    task automatic plan_load(input logic [4:0] rt);
        logic [4:0]  rs;
        logic [15:0] ea;
        logic [15:0] imm;
        rs = 5'($urandom_range(31));
        if (stored_words.size() > 0 && $urandom_range(3) != 0)
            ea = stored_words[$urandom_range(stored_words.size() - 1)];
        else
            ea = 16'($urandom());
        imm = ea - gpr[PLAN][rs][15:0];
        // never read bytes that were not written: fill the word first
        if (!word_ready(PLAN, ea))
            plan_push(mk_exec(mem_ins(OP_SW, rs, 5'($urandom_range(31)), imm)));
        plan_push(mk_exec(mem_ins(OP_LW, rs, rt, imm)));
    endtask

    task automatic plan_store();
        logic [4:0]  rs;
        logic [15:0] ea;
        rs = 5'($urandom_range(31));
        if ($urandom_range(3) == 0)
            ea = 16'hFFFC + 16'($urandom_range(3));
        else
            ea = 16'($urandom());
        plan_push(mk_exec(mem_ins(OP_SW, rs, 5'($urandom_range(31)),
                                  ea - gpr[PLAN][rs][15:0])));
    endtask

    task automatic plan_noise();
        logic [31:0] ins;
        logic [15:0] ea;
        ins = $urandom();
        if (ins == HALT_WORD)
            ins[0] = 1'b0;
        ea = gpr[PLAN][ins[25:21]][15:0] + ins[15:0];
        if (ins[31:26] == OP_LW && !word_ready(PLAN, ea))
            ins[31:26] = OP_SW;
        plan_push(mk_exec(ins));
    endtask

    task automatic plan_other_op();
        logic [31:0] ins;
        ins = $urandom();
        if (ins[31:26] == OP_RTYPE || ins[31:26] == OP_LW || ins[31:26] == OP_SW)
            ins[31:26] = ins[31:26] ^ 6'h10;
        if (ins == HALT_WORD)
            ins[0] = 1'b0;
        plan_push(mk_exec(ins));
    endtask

    task automatic plan_rtype();
        logic [4:0] rd;
        rd = ($urandom_range(7) == 0) ? 5'd0 : 5'($urandom_range(31));
        plan_push(mk_exec(rtype(5'($urandom_range(31)), 5'($urandom_range(31)), rd,
                                3'($urandom_range(7)))));
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end
        else begin
            if (in_valid && !in_stall) begin
                retire_q.push_back(retire_request(CHECK, cur_req));
                sent_cnt++;
            end
            if (!in_valid || !in_stall) begin
                if (req_pending.size() > 0 && (calm || $urandom_range(99) >= 34)) begin
                    cur_req = req_pending.pop_front();
                    req_type <= cur_req.req_type;
                    instruction <= cur_req.instruction;
                    preload_address <= cur_req.paddr;
                    preload_byte <= cur_req.pbyte;
                    in_valid <= 1'b1;
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end
        else begin
            if (out_valid && !out_stall) begin
                if (retire_q.size() == 0) begin
                    $error("result with no request outstanding, kind %0d", kind);
                    errors++;
                end
                else begin
                    exp_res = retire_q.pop_front();
                    kind_seen[exp_res.kind]++;
                    check_field("kind", 32'(exp_res.kind), 32'(kind));
                    check_field("reg_written", 32'(exp_res.reg_written), 32'(reg_written));
                    check_field("dest_reg", 32'(exp_res.dest_reg), 32'(dest_reg));
                    check_field("reg_value", exp_res.reg_value, reg_value);
                    check_field("mem_written", 32'(exp_res.mem_written), 32'(mem_written));
                    check_field("mem_address", 32'(exp_res.mem_address), 32'(mem_address));
                    check_field("mem_value", exp_res.mem_value, mem_value);
                    check_field("halted", 32'(exp_res.halted), 32'(halted));
                end
            end
            out_stall <= !calm && ($urandom_range(99) < 34);
        end
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT)
            @(posedge clk);
        $display("Timeout after %0d cycles", cycle_cnt);
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        cpu_req_t    r;
        int          pick;
        logic [15:0] ea;
        for (int s = 0; s < 2; s++) begin
            for (int i = 0; i < 32; i++)
                gpr[s][i] = '0;
            alu_last[s] = '0;
            halt_flag[s] = 1'b0;
        end
        for (int i = 0; i < 8; i++)
            kind_seen[i] = 0;

        // directed: byte extremes, wrapped and unaligned words, every ALU code
        plan_push(mk_preload(16'h0000, 8'hFF));
        plan_push(mk_preload(16'h0001, 8'h00));
        plan_push(mk_preload(16'h0002, 8'h80));
        plan_push(mk_preload(16'h0003, 8'h7F));
        plan_push(mk_preload(16'h0004, 8'($urandom())));
        plan_push(mk_preload(16'hFFFE, 8'($urandom())));
        plan_push(mk_preload(16'hFFFF, 8'($urandom())));
        plan_push(mk_exec(mem_ins(OP_LW, 5'd0, 5'd1, 16'h0000)));
        plan_push(mk_exec(mem_ins(OP_LW, 5'd0, 5'd2, 16'hFFFE)));   // wraps past the top
        plan_push(mk_exec(mem_ins(OP_LW, 5'd0, 5'd0, 16'h0001)));   // unaligned, into r0
        plan_push(mk_exec(rtype(5'd1, 5'd2, 5'd3, FN_ADDU)));
        plan_push(mk_exec(rtype(5'd1, 5'd2, 5'd4, FN_SUBU)));
        plan_push(mk_exec(rtype(5'd1, 5'd2, 5'd5, FN_AND)));
        plan_push(mk_exec(rtype(5'd1, 5'd2, 5'd6, FN_OR)));
        plan_push(mk_exec(rtype(5'd0, 5'd0, 5'd7, FN_NOR)));
        plan_push(mk_exec(rtype(5'd7, 5'd7, 5'd8, FN_ADDU)));
        plan_push(mk_exec(rtype(5'd3, 5'd4, 5'd9, FN_UNUSED0)));   // unknown codes repeat
        plan_push(mk_exec(rtype(5'd5, 5'd6, 5'd10, FN_UNUSED2)));
        plan_push(mk_exec(rtype(5'd1, 5'd1, 5'd0, FN_UNUSED6)));
        plan_push(mk_exec(rtype(5'd1, 5'd2, 5'd0, FN_ADDU)));
        plan_push(mk_exec(mem_ins(OP_SW, 5'd0, 5'd7, 16'h7FFF)));
        plan_push(mk_exec(mem_ins(OP_SW, 5'd0, 5'd1, 16'h8000)));
        plan_push(mk_exec(mem_ins(OP_SW, 5'd0, 5'd8, 16'hFFFD)));
        plan_push(mk_exec(mem_ins(OP_LW, 5'd0, 5'd11, 16'h7FFF)));
        plan_push(mk_exec(mem_ins(OP_LW, 5'd0, 5'd12, 16'hFFFD)));
        plan_push(mk_exec({OP_ADDI, 26'($urandom())}));
        r = mk_preload(16'h0005, 8'($urandom()));
        r.instruction = HALT_WORD;                                // preload never halts
        plan_push(r);

        for (int i = 0; i < RANDOM_REQS; i++) begin
            pick = $urandom_range(99);
            if (pick < 35)
                plan_rtype();
            else if (pick < 55)
                plan_load(5'($urandom_range(31)));
            else if (pick < 70)
                plan_store();
            else if (pick < 80)
                plan_push(mk_preload(16'($urandom()), 8'($urandom())));
            else if (pick < 90)
                plan_noise();
            else if (pick < 95)
                plan_other_op();
            else begin
                ea = stored_words.size() > 0 ?
                     stored_words[$urandom_range(stored_words.size() - 1)] : 16'($urandom());
                plan_push(mk_preload(ea + 16'($urandom_range(3)), 8'($urandom())));
            end
        end

        // halt, then execute requests are dropped while preloads still land
        plan_push(mk_exec(HALT_WORD));
        plan_rtype();
        plan_rtype();
        plan_store();
        plan_noise();
        plan_push(mk_preload(16'($urandom()), 8'($urandom())));
        plan_push(mk_exec(mem_ins(OP_LW, 5'd0, 5'd1, 16'h0000)));
        plan_other_op();
        plan_push(mk_preload(16'hFFFF, 8'($urandom())));
        plan_push(mk_exec(HALT_WORD));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (req_pending.size() > 0 || in_valid)
            @(negedge clk);
        while (retire_q.size() > 0)
            @(negedge clk);
        repeat (40) @(negedge clk);

        $display("Ran %0d requests: %0d R-type, %0d loads, %0d stores, %0d preloads,",
                 sent_cnt, kind_seen[KIND_RTYPE], kind_seen[KIND_LOAD],
                 kind_seen[KIND_STORE], kind_seen[KIND_PRELOAD]);
        $display("%0d ignored and %0d halt words, %0d mismatches", kind_seen[KIND_IGNORED],
                 kind_seen[KIND_HALT], errors);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
